FILE: design/mbtc_pkg.sv
// Shared types, codes and constants for the Modbus TCP transaction checker.
package mbtc_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_ID   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = CFG_INDEX_W'(1);

    localparam logic [7:0] UNIT_ID_RESET   = 8'hFF;
    localparam logic [3:0] THRESHOLD_RESET = 4'd3;

    localparam logic [2:0] OP_CONNECT    = 3'd0;
    localparam logic [2:0] OP_REQUEST    = 3'd1;
    localparam logic [2:0] OP_RX_BYTE    = 3'd2;
    localparam logic [2:0] OP_TIMEOUT    = 3'd3;
    localparam logic [2:0] OP_DISCONNECT = 3'd4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ID      = 3'd1;
    localparam logic [2:0] ST_PROTO   = 3'd2;
    localparam logic [2:0] ST_LEN     = 3'd3;
    localparam logic [2:0] ST_EXC     = 3'd4;
    localparam logic [2:0] ST_FUNC    = 3'd5;
    localparam logic [2:0] ST_TIMEOUT = 3'd6;
    localparam logic [2:0] ST_DOWN    = 3'd7;

    localparam logic [2:0]  MBAP_LAST_IDX = 3'd6;
    localparam logic [15:0] MIN_LEN       = 16'd2;
    localparam logic [15:0] MAX_LEN       = 16'd253;
    localparam logic [3:0]  HEADER_COUNT  = 4'd8;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] func_code;
        logic [7:0] data_len;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic       peer_responded;
        logic       link_up;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [3:0]      count;
        logic            hdr;
        logic            pay;
        logic [7:0][7:0] bytes;
        logic [2:0]      status;
        logic [7:0]      exc;
        logic            peer;
        logic            last;
        logic            link_up;
    } batch_t;

endpackage

FILE: design/mbtc_engine.sv
// Transaction state and per-item decode into a batch of results.
module mbtc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mbtc_pkg::item_t   item,
    input  logic [7:0]        unit_id,
    input  logic [3:0]        threshold,
    output mbtc_pkg::batch_t  batch
);

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_FUNC, PH_BODY} phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tid_reg, tid_next;
    logic [6:0]  fn_reg, fn_next;
    logic [2:0]  bidx_reg, bidx_next;
    logic [47:0] hshift_reg, hshift_next;
    logic [7:0]  remain_reg, remain_next;
    logic [2:0]  pend_reg, pend_next;
    logic [7:0]  exc_reg, exc_next;
    logic [3:0]  fail_reg, fail_next;
    logic        conn_reg, conn_next;

    logic        clr;
    logic        start;
    logic        ok_event;
    logic        fail_event;
    logic        close;
    logic [3:0]  fail_inc;
    logic [15:0] tid_inc;
    logic [8:0]  len9;
    logic [15:0] rx_len;
    logic [7:0]  rem_dec;
    logic [2:0]  close_st;
    logic [7:0]  close_exc;

    assign fail_inc = fail_reg + 4'd1;
    assign tid_inc  = tid_reg + 16'd1;
    assign len9     = 9'd2 + {1'b0, item.data_len};
    assign rx_len   = hshift_reg[15:0];
    assign rem_dec  = (remain_reg != 8'd0) ? remain_reg - 8'd1 : 8'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        tid_next    = tid_reg;
        fn_next     = fn_reg;
        bidx_next   = bidx_reg;
        hshift_next = hshift_reg;
        remain_next = remain_reg;
        pend_next   = pend_reg;
        exc_next    = exc_reg;
        fail_next   = fail_reg;
        conn_next   = conn_reg;
        clr         = 1'b0;
        start       = 1'b0;
        ok_event    = 1'b0;
        fail_event  = 1'b0;
        close       = 1'b0;
        close_st    = mbtc_pkg::ST_OK;
        close_exc   = 8'd0;
        batch       = '0;

        unique case (item.opcode)
            mbtc_pkg::OP_CONNECT:
            begin
                if (!conn_reg)
                begin
                    conn_next = 1'b1;
                    tid_next  = 16'd0;
                    fail_next = 4'd0;
                    clr       = 1'b1;
                end
                batch.count = 4'd1;
            end
            mbtc_pkg::OP_REQUEST:
            begin
                if (!conn_reg)
                begin
                    batch.count  = 4'd1;
                    batch.status = mbtc_pkg::ST_DOWN;
                    batch.last   = 1'b1;
                end
                else
                begin
                    clr         = 1'b1;
                    start       = 1'b1;
                    tid_next    = tid_inc;
                    fn_next     = item.func_code;
                    batch.count = mbtc_pkg::HEADER_COUNT;
                    batch.hdr   = 1'b1;
                    batch.bytes[0] = tid_inc[15:8];
                    batch.bytes[1] = tid_inc[7:0];
                    batch.bytes[2] = 8'd0;
                    batch.bytes[3] = 8'd0;
                    batch.bytes[4] = {7'd0, len9[8]};
                    batch.bytes[5] = len9[7:0];
                    batch.bytes[6] = unit_id;
                    batch.bytes[7] = {1'b0, item.func_code};
                end
            end
            mbtc_pkg::OP_RX_BYTE:
            begin
                if (phase_reg == PH_HEADER)
                begin
                    if (bidx_reg < mbtc_pkg::MBAP_LAST_IDX)
                    begin
                        hshift_next = {hshift_reg[39:0], item.rx_byte};
                        bidx_next   = bidx_reg + 3'd1;
                    end
                    else if (hshift_reg[47:32] != tid_reg)
                    begin
                        clr = 1'b1; fail_event = 1'b1;
                        batch.count = 4'd1; batch.status = mbtc_pkg::ST_ID;
                        batch.last = 1'b1;
                    end
                    else if (hshift_reg[31:16] != 16'd0)
                    begin
                        clr = 1'b1; fail_event = 1'b1;
                        batch.count = 4'd1; batch.status = mbtc_pkg::ST_PROTO;
                        batch.last = 1'b1;
                    end
                    else if (rx_len < mbtc_pkg::MIN_LEN || rx_len > mbtc_pkg::MAX_LEN)
                    begin
                        clr = 1'b1; fail_event = 1'b1;
                        batch.count = 4'd1; batch.status = mbtc_pkg::ST_LEN;
                        batch.last = 1'b1;
                    end
                    else
                    begin
                        remain_next = rx_len[7:0] - 8'd1;
                        bidx_next   = 3'd0;
                        phase_next  = PH_FUNC;
                    end
                end
                else if (phase_reg == PH_FUNC || phase_reg == PH_BODY)
                begin
                    if (phase_reg == PH_FUNC)
                    begin
                        if (item.rx_byte == {1'b1, fn_reg})
                        begin
                            pend_next = mbtc_pkg::ST_EXC;
                            exc_next  = 8'd0;
                        end
                        else if (item.rx_byte != {1'b0, fn_reg})
                        begin
                            pend_next = mbtc_pkg::ST_FUNC;
                        end
                        else
                        begin
                            pend_next = mbtc_pkg::ST_OK;
                        end
                        bidx_next  = 3'd0;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        if (pend_reg == mbtc_pkg::ST_OK)
                        begin
                            batch.count    = 4'd1;
                            batch.pay      = 1'b1;
                            batch.bytes[0] = item.rx_byte;
                        end
                        else if (pend_reg == mbtc_pkg::ST_EXC && bidx_reg == 3'd0)
                        begin
                            exc_next = item.rx_byte;
                        end
                        if (bidx_reg != 3'd7)
                        begin
                            bidx_next = bidx_reg + 3'd1;
                        end
                    end
                    remain_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        close     = 1'b1;
                        close_st  = pend_next;
                        close_exc = (pend_next == mbtc_pkg::ST_EXC) ? exc_next : 8'd0;
                        clr       = 1'b1;
                        ok_event  = 1'b1;
                    end
                end
            end
            mbtc_pkg::OP_TIMEOUT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    clr = 1'b1; fail_event = 1'b1;
                    batch.count = 4'd1; batch.status = mbtc_pkg::ST_TIMEOUT;
                    batch.last = 1'b1;
                end
            end
            mbtc_pkg::OP_DISCONNECT:
            begin
                conn_next   = 1'b0;
                clr         = 1'b1;
                batch.count = 4'd1;
            end
            default:
            begin
            end
        endcase

        if (close)
        begin
            batch.count  = batch.count + 4'd1;
            batch.status = close_st;
            batch.exc    = close_exc;
            batch.peer   = 1'b1;
            batch.last   = 1'b1;
        end

        if (clr)
        begin
            phase_next  = PH_IDLE;
            bidx_next   = 3'd0;
            hshift_next = 48'd0;
            remain_next = 8'd0;
            pend_next   = mbtc_pkg::ST_OK;
            exc_next    = 8'd0;
        end
        if (start)
        begin
            phase_next = PH_HEADER;
        end

        if (ok_event)
        begin
            fail_next = 4'd0;
        end
        else if (fail_event)
        begin
            if (fail_inc >= threshold)
            begin
                conn_next = 1'b0;
                fail_next = 4'd0;
            end
            else
            begin
                fail_next = fail_inc;
            end
        end

        batch.link_up = conn_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tid_reg    <= 16'd0;
            fn_reg     <= 7'd0;
            bidx_reg   <= 3'd0;
            hshift_reg <= 48'd0;
            remain_reg <= 8'd0;
            pend_reg   <= mbtc_pkg::ST_OK;
            exc_reg    <= 8'd0;
            fail_reg   <= 4'd0;
            conn_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            tid_reg    <= tid_next;
            fn_reg     <= fn_next;
            bidx_reg   <= bidx_next;
            hshift_reg <= hshift_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
            exc_reg    <= exc_next;
            fail_reg   <= fail_next;
            conn_reg   <= conn_next;
        end
    end

endmodule

FILE: design/mbtc_serializer.sv
// Result register that holds one batch and sends its results one per cycle unless stalled.
module mbtc_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mbtc_pkg::batch_t  batch,
    output logic              can_load,
    output logic              result_valid,
    input  logic              result_stall,
    output mbtc_pkg::result_t result
);

    mbtc_pkg::batch_t batch_reg;
    logic [3:0]       count_reg;
    logic [2:0]       idx_reg;
    logic             take;
    logic             final_take;

    assign result_valid = (count_reg != 4'd0);
    assign take         = result_valid && !result_stall;
    assign final_take   = take && (idx_reg == 3'(count_reg - 4'd1));
    assign can_load     = !result_valid || final_take;

    always_comb
    begin
        result         = '0;
        result.link_up = batch_reg.link_up;
        if (batch_reg.hdr)
        begin
            result.out_kind = mbtc_pkg::KIND_HEADER;
            result.out_byte = batch_reg.bytes[idx_reg];
            result.last     = (idx_reg == 3'd7);
        end
        else if (batch_reg.pay && idx_reg == 3'd0)
        begin
            result.out_kind = mbtc_pkg::KIND_PAYLOAD;
            result.out_byte = batch_reg.bytes[0];
        end
        else
        begin
            result.out_kind       = mbtc_pkg::KIND_STATUS;
            result.status         = batch_reg.status;
            result.exception_code = batch_reg.exc;
            result.peer_responded = batch_reg.peer;
            result.last           = batch_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && batch.count != 4'd0)
        begin
            batch_reg <= batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
            idx_reg   <= 3'd0;
        end
        else if (fire && batch.count != 4'd0)
        begin
            count_reg <= batch.count;
            idx_reg   <= 3'd0;
        end
        else if (final_take)
        begin
            count_reg <= 4'd0;
            idx_reg   <= 3'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

FILE: design/modbus_tcp_transaction_checker_top.sv
// Latency: an item's first result is valid the cycle after the item is taken.
// Throughput: one item per cycle with no result stall while each item makes at
// most one result; an item making n results holds the input until its last result
// is taken, and the next item is taken in that cycle (a request makes eight header
// results when linked). Reset: rst_n is asynchronous, active low; link down, ids
// and counts clear, unit_id returns to 0xFF and failure_threshold to 3.
module modbus_tcp_transaction_checker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  mbtc_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mbtc_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbtc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbtc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic             fire;
    logic             can_load;
    logic [7:0]       unit_id_reg;
    logic [3:0]       threshold_reg;
    mbtc_pkg::batch_t batch;

    assign cfg_ready  = 1'b1;
    assign item_stall = !can_load;
    assign fire       = item_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_id_reg   <= mbtc_pkg::UNIT_ID_RESET;
            threshold_reg <= mbtc_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbtc_pkg::CFG_UNIT_ID:   unit_id_reg   <= cfg_data[7:0];
                mbtc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    mbtc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .unit_id   (unit_id_reg),
        .threshold (threshold_reg),
        .batch     (batch)
    );

    mbtc_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .batch        (batch),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item stalled with no result pending");

    a_header_link_up: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_kind == mbtc_pkg::KIND_HEADER) |-> result.link_up)
        else $error("header result sent while link down");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_kind == mbtc_pkg::KIND_PAYLOAD)
        |-> (result.status == mbtc_pkg::ST_OK && !result.last && result.link_up))
        else $error("payload result carries status or last");

    a_request_starts_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.opcode == mbtc_pkg::OP_REQUEST) |=> result_valid)
        else $error("request produced no result");
`endif

endmodule

FILE: bench/modbus_tcp_transaction_checker_top_tb.sv
// Self-checking testbench for the Modbus TCP transaction checker.
module modbus_tcp_transaction_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_LEN      = 300;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_FUNC,
        PARSE_BODY
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    mbtc_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    mbtc_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mbtc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mbtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic quiet = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;
    int cycles = 0;
    int errors = 0;
    int items_sent = 0;

    // engine state as the block should hold it
    logic [7:0]   unit_q = mbtc_pkg::UNIT_ID_RESET;
    logic [3:0]   thresh_q = mbtc_pkg::THRESHOLD_RESET;
    logic [15:0]  txn_id_q = '0;
    logic [6:0]   exp_func_q = '0;
    parse_phase_t phase_q = PARSE_IDLE;
    logic [7:0]   idx_q = '0;
    logic [47:0]  mbap_q = '0;
    logic [7:0]   body_left_q = '0;
    logic [2:0]   pend_st_q = mbtc_pkg::ST_OK;
    logic [7:0]   held_exc_q = '0;
    logic [3:0]   fail_cnt_q = '0;
    logic         link_q = 1'b0;

    mbtc_pkg::result_t engine_out_q[$];

    modbus_tcp_transaction_checker_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_out(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [2:0] st, input logic [7:0] exc,
                                     input logic peer, input logic closing);
        mbtc_pkg::result_t r;
        r.out_kind       = kind;
        r.out_byte       = b;
        r.status         = st;
        r.exception_code = exc;
        r.peer_responded = peer;
        r.link_up        = link_q;
        r.last           = closing;
        engine_out_q     = {engine_out_q, r};
    endfunction

    function automatic void clear_parse();
        phase_q     = PARSE_IDLE;
        idx_q       = '0;
        mbap_q      = '0;
        body_left_q = '0;
        pend_st_q   = mbtc_pkg::ST_OK;
        held_exc_q  = '0;
    endfunction

    function automatic void count_outcome(input logic good);
        if (good)
        begin
            fail_cnt_q = '0;
        end
        else
        begin
            fail_cnt_q = fail_cnt_q + 4'd1;
            if (fail_cnt_q >= thresh_q)
            begin
                link_q     = 1'b0;
                fail_cnt_q = '0;
            end
        end
    endfunction

    function automatic void engine_rx(input logic [7:0] b);
        logic [15:0] rid;
        logic [15:0] proto;
        logic [15:0] len;
        logic [2:0]  st;
        logic [7:0]  exc;
        if (phase_q == PARSE_HEADER)
        begin
            if (idx_q < 8'(mbtc_pkg::MBAP_LAST_IDX))
            begin
                mbap_q = {mbap_q[39:0], b};
                idx_q  = idx_q + 8'd1;
            end
            else
            begin
                rid   = mbap_q[47:32];
                proto = mbap_q[31:16];
                len   = mbap_q[15:0];
                st    = mbtc_pkg::ST_OK;
                if (rid != txn_id_q)
                    st = mbtc_pkg::ST_ID;
                else if (proto != 16'd0)
                    st = mbtc_pkg::ST_PROTO;
                else if (len < mbtc_pkg::MIN_LEN || len > mbtc_pkg::MAX_LEN)
                    st = mbtc_pkg::ST_LEN;
                if (st != mbtc_pkg::ST_OK)
                begin
                    clear_parse();
                    count_outcome(1'b0);
                    push_out(mbtc_pkg::KIND_STATUS, 8'd0, st, 8'd0, 1'b0, 1'b1);
                end
                else
                begin
                    body_left_q = 8'(len - 16'd1);
                    idx_q       = '0;
                    phase_q     = PARSE_FUNC;
                end
            end
        end
        else if (phase_q == PARSE_FUNC || phase_q == PARSE_BODY)
        begin
            if (phase_q == PARSE_FUNC)
            begin
                if (b == {1'b1, exp_func_q})
                begin
                    pend_st_q  = mbtc_pkg::ST_EXC;
                    held_exc_q = '0;
                end
                else if (b != {1'b0, exp_func_q})
                    pend_st_q = mbtc_pkg::ST_FUNC;
                else
                    pend_st_q = mbtc_pkg::ST_OK;
                idx_q   = '0;
                phase_q = PARSE_BODY;
            end
            else
            begin
                if (pend_st_q == mbtc_pkg::ST_OK)
                    push_out(mbtc_pkg::KIND_PAYLOAD, b, mbtc_pkg::ST_OK, 8'd0, 1'b0, 1'b0);
                else if (pend_st_q == mbtc_pkg::ST_EXC && idx_q == 8'd0)
                    held_exc_q = b;
                if (idx_q != 8'hFF)
                    idx_q = idx_q + 8'd1;
            end
            if (body_left_q != 8'd0)
                body_left_q = body_left_q - 8'd1;
            if (body_left_q == 8'd0)
            begin
                st  = pend_st_q;
                exc = (st == mbtc_pkg::ST_EXC) ? held_exc_q : 8'd0;
                clear_parse();
                count_outcome(1'b1);
                push_out(mbtc_pkg::KIND_STATUS, 8'd0, st, exc, 1'b1, 1'b1);
            end
        end
    endfunction

    function automatic void engine_step(input mbtc_pkg::item_t it);
        logic [15:0] len;
        logic [63:0] hdr;
        case (it.opcode)
            mbtc_pkg::OP_CONNECT:
            begin
                if (!link_q)
                begin
                    link_q     = 1'b1;
                    txn_id_q   = '0;
                    fail_cnt_q = '0;
                    clear_parse();
                end
                push_out(mbtc_pkg::KIND_STATUS, 8'd0, mbtc_pkg::ST_OK, 8'd0, 1'b0, 1'b0);
            end
            mbtc_pkg::OP_REQUEST:
            begin
                if (!link_q)
                begin
                    push_out(mbtc_pkg::KIND_STATUS, 8'd0, mbtc_pkg::ST_DOWN, 8'd0,
                             1'b0, 1'b1);
                end
                else
                begin
                    clear_parse();
                    txn_id_q = txn_id_q + 16'd1;
                    len      = 16'd2 + 16'(it.data_len);
                    hdr      = {txn_id_q, 16'h0000, len, unit_q, 1'b0, it.func_code};
                    for (int i = 0; i < 8; i++)
                        push_out(mbtc_pkg::KIND_HEADER, hdr[63 - 8 * i -: 8],
                                 mbtc_pkg::ST_OK, 8'd0, 1'b0, i == 7);
                    exp_func_q = it.func_code;
                    phase_q    = PARSE_HEADER;
                end
            end
            mbtc_pkg::OP_RX_BYTE:
            begin
                engine_rx(it.rx_byte);
            end
            mbtc_pkg::OP_TIMEOUT:
            begin
                if (phase_q != PARSE_IDLE)
                begin
                    clear_parse();
                    count_outcome(1'b0);
                    push_out(mbtc_pkg::KIND_STATUS, 8'd0, mbtc_pkg::ST_TIMEOUT, 8'd0,
                             1'b0, 1'b1);
                end
            end
            mbtc_pkg::OP_DISCONNECT:
            begin
                link_q = 1'b0;
                clear_parse();
                push_out(mbtc_pkg::KIND_STATUS, 8'd0, mbtc_pkg::ST_OK, 8'd0, 1'b0, 1'b0);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t mismatch in %s: expected %0h, got %0h", $time, what, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        mbtc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (engine_out_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'd0, 32'(result));
            end
            else
            begin
                want = engine_out_q.pop_front();
                if (result.out_kind !== want.out_kind)
                    report_mismatch("out_kind", 32'(want.out_kind), 32'(result.out_kind));
                if (result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(result.out_byte));
                if (result.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(result.status));
                if (result.exception_code !== want.exception_code)
                    report_mismatch("exception_code", 32'(want.exception_code),
                                    32'(result.exception_code));
                if (result.peer_responded !== want.peer_responded)
                    report_mismatch("peer_responded", 32'(want.peer_responded),
                                    32'(result.peer_responded));
                if (result.link_up !== want.link_up)
                    report_mismatch("link_up", 32'(want.link_up), 32'(result.link_up));
                if (result.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // result stall: random gaps, plus a long hold when a test asks for one
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served  <= hold_requests;
            stall_left   <= HOLD_LEN;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic mbtc_pkg::item_t rand_item(input logic [2:0] op);
        mbtc_pkg::item_t it;
        it.opcode    = op;
        it.func_code = 7'($urandom);
        it.data_len  = 8'($urandom_range(0, 251));
        it.rx_byte   = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input mbtc_pkg::item_t it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        engine_step(it);
        items_sent++;
    endtask

    task automatic send_op(input logic [2:0] op);
        send_item(rand_item(op));
    endtask

    task automatic send_rx(input logic [7:0] b);
        mbtc_pkg::item_t it;
        it         = rand_item(mbtc_pkg::OP_RX_BYTE);
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_request(input logic [6:0] fc);
        mbtc_pkg::item_t it;
        it           = rand_item(mbtc_pkg::OP_REQUEST);
        it.func_code = fc;
        send_item(it);
    endtask

    // send the first count bytes of a response: MBAP header, function byte, random body
    task automatic send_frame(input logic [15:0] tid, input logic [15:0] proto,
                              input logic [15:0] len, input logic [7:0] func_byte,
                              input int count);
        logic [55:0] mbap;
        logic [7:0]  b;
        mbap = {tid, proto, len, 8'($urandom)};
        for (int i = 0; i < count; i++)
        begin
            if (i < 7)
                b = mbap[55 - 8 * i -: 8];
            else if (i == 7)
                b = func_byte;
            else
                b = 8'($urandom);
            send_rx(b);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (engine_out_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mbtc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mbtc_pkg::CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mbtc_pkg::CFG_UNIT_ID)
            unit_q = val;
        else if (idx == mbtc_pkg::CFG_THRESHOLD)
            thresh_q = val[3:0];
    endtask

    task automatic good_exchange();
        logic [6:0]  fc;
        logic [15:0] len;
        logic [7:0]  func_byte;
        int shape;
        if (!link_q)
            send_op(mbtc_pkg::OP_CONNECT);
        fc = 7'($urandom);
        send_request(fc);
        len   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                            : 16'($urandom_range(2, 8));
        shape = $urandom_range(0, 5);
        if (shape < 4)
            func_byte = {1'b0, fc};
        else if (shape == 4)
            func_byte = {1'b1, fc};
        else
        begin
            do
                func_byte = 8'($urandom);
            while (func_byte == {1'b0, fc} || func_byte == {1'b1, fc});
        end
        send_frame(txn_id_q, 16'd0, len, func_byte, 6 + int'(len));
    endtask

    task automatic broken_exchange();
        logic [6:0]  fc;
        logic [15:0] len;
        logic [15:0] bad_len;
        int k;
        if (!link_q)
            send_op(mbtc_pkg::OP_CONNECT);
        fc = 7'($urandom);
        send_request(fc);
        len = 16'($urandom_range(2, 8));
        case ($urandom_range(0, 5))
            0: send_frame(txn_id_q ^ 16'($urandom_range(1, 65535)), 16'd0, len,
                          {1'b0, fc}, 7);
            1: send_frame(txn_id_q, 16'($urandom_range(1, 65535)), len, {1'b0, fc}, 7);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: bad_len = 16'd0;
                    1: bad_len = 16'd1;
                    2: bad_len = mbtc_pkg::MAX_LEN + 16'd1;
                    default: bad_len = 16'($urandom_range(255, 65535));
                endcase
                send_frame(txn_id_q, 16'd0, bad_len, {1'b0, fc}, 7);
            end
            3:
            begin
                k = $urandom_range(0, 5 + int'(len));
                send_frame(txn_id_q, 16'd0, len, {1'b0, fc}, k);
                send_op(mbtc_pkg::OP_TIMEOUT);
            end
            4:
            begin
                // drop mid-frame: either hang up or leave it for the next request
                k = $urandom_range(0, 5 + int'(len));
                send_frame(txn_id_q, 16'd0, len, {1'b0, fc}, k);
                if ($urandom_range(0, 1) == 0)
                    send_op(mbtc_pkg::OP_DISCONNECT);
            end
            default: send_op(mbtc_pkg::OP_TIMEOUT);
        endcase
    endtask

    task automatic run_traffic(input int n_items);
        int stop_at;
        int roll;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_op(mbtc_pkg::OP_CONNECT);
            else if (roll < 7)
                send_op(mbtc_pkg::OP_DISCONNECT);
            else if (roll < 12)
                send_item(rand_item(3'($urandom_range(0, 7))));
            else if (roll < 24)
                broken_exchange();
            else
                good_exchange();
        end
    endtask

    task automatic test_basics();
        send_request(7'h03);
        send_op(mbtc_pkg::OP_RX_BYTE);
        send_op(mbtc_pkg::OP_TIMEOUT);
        send_op(3'd5);
        send_op(3'd6);
        send_op(3'd7);
        send_op(mbtc_pkg::OP_DISCONNECT);
        send_op(mbtc_pkg::OP_CONNECT);
        send_op(mbtc_pkg::OP_CONNECT);
        send_item('{opcode: mbtc_pkg::OP_REQUEST, func_code: 7'h00, data_len: 8'd0,
                    rx_byte: 8'h00});
        send_item('{opcode: mbtc_pkg::OP_REQUEST, func_code: 7'h7F, data_len: 8'd251,
                    rx_byte: 8'hFF});
        // exception frame carrying the function byte only
        send_frame(txn_id_q, 16'd0, 16'd2, 8'hFF, 8);
        send_request(7'h55);
        send_op(mbtc_pkg::OP_TIMEOUT);
    endtask

    task automatic test_config_sweep();
        logic [7:0] units [5];
        logic [3:0] limits [5];
        units  = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'($urandom)};
        limits = '{4'd1, 4'd15, 4'd2, 4'd3, 4'($urandom_range(1, 15))};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(mbtc_pkg::CFG_UNIT_ID, units[p]);
            write_reg(mbtc_pkg::CFG_THRESHOLD, {4'h0, limits[p]});
            quiet <= (p == 2);
            run_traffic(10);
        end
    endtask

    task automatic test_pressure();
        if (!link_q)
            send_op(mbtc_pkg::OP_CONNECT);
        quiet         <= 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (12) send_request(7'($urandom));
        quiet <= 1'b0;
    endtask

    task automatic test_long_frame();
        logic [6:0] fc;
        if (!link_q)
            send_op(mbtc_pkg::OP_CONNECT);
        fc = 7'($urandom);
        send_request(fc);
        send_frame(txn_id_q, 16'd0, mbtc_pkg::MAX_LEN, {1'b0, fc},
                   6 + int'(mbtc_pkg::MAX_LEN));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basics();
        test_config_sweep();
        test_pressure();
        test_long_frame();
        item_valid <= 1'b0;
        while (engine_out_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (engine_out_q.size() != 0)
            report_mismatch("results still outstanding", 32'd0, engine_out_q.size());
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
